[rtl/md5_message_digest_defines.svh]
// assertion helpers for the digest block
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// check a property on every clock edge outside reset
`define MD5_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property including the reset cycles
`define MD5_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/md5_pkg.sv]
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS = 6'd56;
   localparam logic [1:0]  LAST_WORD_IDX = 2'd3;

   typedef struct packed {
      logic take_byte;
      logic pad_start;
      logic pad_write;
      logic pad_next;
      logic blk_start;
      logic round_step;
      logic blk_add;
      logic out_word;
      logic msg_clear;
   } cmd_type;

   typedef struct packed {
      logic       fill_last;
      logic       pad_last;
      logic       pad_active;
      logic       pad_final;
      logic       round_last;
      logic       out_last;
      logic       out_free;
   } status_type;

   function automatic logic [31:0] step_const(input logic [5:0] i);
      logic [31:0] k;
      begin
         case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

   function automatic logic [4:0] step_rot(input logic [1:0] rnd, input logic [1:0] j);
      logic [4:0] s;
      begin
         case ({rnd, j})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
         endcase
         return s;
      end
   endfunction

endpackage

[rtl/md5_message_digest.sv]
// channel   dir  tdata                 tuser          tlast
// req_      in   [7:0] data_byte       byte_valid     end_of_message
// rsp_      out  [31:0] digest_word    word_index     last_word
//
// a request is taken when the block is idle
// the byte that fills a block starts a compression: load, 64 rounds, chaining add
// end of message pads one byte per cycle up to the block end, then one or two
// compressions, then four digest words paced by rsp_tready
// synchronous reset restores the initial chaining words and a zero count
// the last digest word may wait in its output register while a new request is taken
module md5_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast
);
   import md5_pkg::*;

   `include "md5_message_digest_defines.svh"

   cmd_type    cmd;
   status_type sts;
   logic       in_ready;
   logic       req_fire;

   assign req_tready = in_ready;
   assign req_fire   = req_tvalid && in_ready;

   md5_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_byte_valid (req_tuser),
      .req_end        (req_tlast),
      .sts            (sts),
      .cmd            (cmd),
      .in_ready       (in_ready)
   );

   md5_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_tdata),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .rsp_valid (rsp_tvalid),
      .rsp_word  (rsp_tdata),
      .rsp_index (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   `MD5_ASSERT(a_last_idx, rsp_tvalid |-> (rsp_tlast == (rsp_tuser == LAST_WORD_IDX)), "last flag and word index disagree")
   `MD5_ASSERT(a_idle_no_pad, req_tready |-> !sts.pad_active, "request taken while padding")
   `MD5_ASSERT(a_out_needs_room, cmd.out_word |-> sts.out_free, "digest word overwrote a pending word")
   `MD5_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

[rtl/md5_ctrl.sv]
module md5_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               req_byte_valid,
   input  logic               req_end,
   input  md5_pkg::status_type sts,
   output md5_pkg::cmd_type   cmd,
   output logic               in_ready
);
   import md5_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      end_pending_ff, end_pending_in;

   always_comb begin
      state_in       = state_ff;
      end_pending_in = end_pending_ff;
      cmd            = '0;
      in_ready       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (req_fire) begin
               cmd.take_byte = req_byte_valid;
               if (req_byte_valid && sts.fill_last) begin
                  end_pending_in = req_end;
                  state_in       = ST_LOAD;
               end else if (req_end) begin
                  cmd.pad_start = 1'b1;
                  state_in      = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.pad_write = 1'b1;
            if (sts.pad_last) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.blk_start = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (sts.round_last) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.blk_add = 1'b1;
            if (sts.pad_active) begin
               if (sts.pad_final) begin
                  state_in = ST_OUT;
               end else begin
                  cmd.pad_next = 1'b1;
                  state_in     = ST_PAD;
               end
            end else if (end_pending_ff) begin
               // end arrived with the byte that filled the block
               cmd.pad_start  = 1'b1;
               end_pending_in = 1'b0;
               state_in       = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_word = 1'b1;
               if (sts.out_last) begin
                  cmd.msg_clear = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         end_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         end_pending_ff <= end_pending_in;
      end
   end

endmodule

[rtl/md5_datapath.sv]
module md5_datapath (
   input  logic               clock,
   input  logic               reset,
   input  md5_pkg::cmd_type   cmd,
   input  logic [7:0]         data_byte,
   input  logic               rsp_ready,
   output md5_pkg::status_type sts,
   output logic               rsp_valid,
   output logic [31:0]        rsp_word,
   output logic [1:0]         rsp_index,
   output logic               rsp_last
);
   import md5_pkg::*;

   logic [31:0] blk_ff [16];
   logic [31:0] cw_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [63:0] count_ff;
   logic [5:0]  pad_ptr_ff;
   logic        pad_first_ff, pad_final_ff, pad_active_ff;
   logic [5:0]  rnd_ff;
   logic [1:0]  out_idx_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff;
   logic [1:0]  rsp_index_ff;
   logic        rsp_last_ff;

   logic [5:0]  fill;
   logic [5:0]  pad_pos;
   logic [63:0] bit_count;
   logic [7:0]  pad_byte;
   logic [1:0]  rnd_grp;
   logic [3:0]  g_idx;
   logic [31:0] f_val, sum, rot;
   logic [4:0]  sh;
   logic [5:0]  wr_pos;
   logic [7:0]  wr_byte;
   logic        wr_en;

   assign fill      = count_ff[5:0];
   assign bit_count = {count_ff[60:0], 3'b000};
   assign rnd_grp   = rnd_ff[5:4];
   // padding starts after the byte taken with the end flag, if any
   assign pad_pos   = fill + {5'd0, cmd.take_byte};

   always_comb begin
      if (pad_first_ff) begin
         pad_byte = PAD_BYTE;
      end else if (pad_final_ff && pad_ptr_ff >= LEN_POS) begin
         pad_byte = bit_count[{pad_ptr_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign wr_en   = cmd.take_byte || cmd.pad_write;
   assign wr_pos  = cmd.take_byte ? fill : pad_ptr_ff;
   assign wr_byte = cmd.take_byte ? data_byte : pad_byte;

   // one compression step per cycle
   always_comb begin
      case (rnd_grp)
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            g_idx = rnd_ff[3:0];
         end
         2'd1: begin
            f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
            g_idx = rnd_ff[3:0] * 4'd5 + 4'd1;
         end
         2'd2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            g_idx = rnd_ff[3:0] * 4'd3 + 4'd5;
         end
         default: begin
            f_val = c_ff ^ (b_ff | ~d_ff);
            g_idx = rnd_ff[3:0] * 4'd7;
         end
      endcase
      sh  = step_rot(rnd_grp, rnd_ff[1:0]);
      sum = a_ff + f_val + step_const(rnd_ff) + blk_ff[g_idx];
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   always_ff @(posedge clock) begin
      if (wr_en) blk_ff[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
      if (cmd.blk_start) begin
         a_ff <= cw_ff[0];
         b_ff <= cw_ff[1];
         c_ff <= cw_ff[2];
         d_ff <= cw_ff[3];
      end else if (cmd.round_step) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rot;
      end
      if (cmd.out_word) begin
         rsp_word_ff  <= cw_ff[out_idx_ff];
         rsp_index_ff <= out_idx_ff;
         rsp_last_ff  <= (out_idx_ff == LAST_WORD_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.msg_clear) begin
         cw_ff[0]      <= INIT_A;
         cw_ff[1]      <= INIT_B;
         cw_ff[2]      <= INIT_C;
         cw_ff[3]      <= INIT_D;
         count_ff      <= '0;
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         pad_final_ff  <= 1'b0;
         pad_ptr_ff    <= '0;
         out_idx_ff    <= '0;
      end else begin
         if (cmd.take_byte) count_ff <= count_ff + 64'd1;
         if (cmd.blk_add) begin
            cw_ff[0] <= cw_ff[0] + a_ff;
            cw_ff[1] <= cw_ff[1] + b_ff;
            cw_ff[2] <= cw_ff[2] + c_ff;
            cw_ff[3] <= cw_ff[3] + d_ff;
         end
         if (cmd.pad_start) begin
            pad_active_ff <= 1'b1;
            pad_first_ff  <= 1'b1;
            pad_final_ff  <= (pad_pos < LEN_POS);
            pad_ptr_ff    <= pad_pos;
         end else if (cmd.pad_next) begin
            pad_final_ff <= 1'b1;
            pad_ptr_ff   <= '0;
         end else if (cmd.pad_write) begin
            pad_first_ff <= 1'b0;
            pad_ptr_ff   <= pad_ptr_ff + 6'd1;
         end
         if (cmd.out_word) out_idx_ff <= out_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.blk_start) rnd_ff <= '0;
         else if (cmd.round_step) rnd_ff <= rnd_ff + 6'd1;
         if (cmd.out_word) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.fill_last  = (fill == 6'd63);
   assign sts.pad_last   = (pad_ptr_ff == 6'd63);
   assign sts.pad_active = pad_active_ff;
   assign sts.pad_final  = pad_final_ff;
   assign sts.round_last = (rnd_ff == 6'd63);
   assign sts.out_last   = (out_idx_ff == LAST_WORD_IDX);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
